>>> rtl/core/hpbd_pkg.sv
// Package for the heatmap peak box decoder: fixed-point widths, grid and
// class limits, register indexes and reset values. No dependencies.
`default_nettype none

package hpbd_pkg;

  // Grid and network geometry
  localparam int STRIDE      = 4;
  localparam int GRID_DIM    = 128;
  localparam int NUM_CLASSES = 128;
  localparam int MAX_IMAGE   = 4096;
  localparam int FRAC_SHIFT  = 25;

  // Field widths
  localparam int SCORE_W = 16;
  localparam int OFS_W   = 16;
  localparam int SIZE_W  = 16;
  localparam int CELL_W  = 7;
  localparam int CLASS_W = 7;
  localparam int DIM_W   = 13;
  localparam int SCALE_W = 24;
  localparam int LEFT_W  = 12;
  localparam int RIGHT_W = 13;

  // Internal arithmetic widths
  localparam int EDGE_W  = 19;                   // edge in 1/512 cell
  localparam int DIST_W  = 25;                   // distance in 1/512 pixel
  localparam int PROD_W  = DIST_W + SCALE_W + 3; // position in 2^-25 pixel
  localparam int COORD_W = PROD_W - FRAC_SHIFT;  // whole pixels, signed

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NET_WIDTH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NET_HEIGHT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE   = 3'd5;

  localparam logic [SCORE_W-1:0] RST_SCORE_THRESHOLD = 16'd19661;
  localparam logic [DIM_W-1:0]   RST_DIM             = 13'd512;
  localparam logic [SCALE_W-1:0] RST_INVERSE_SCALE   = 24'd65536;

  // Per-axis mapping setup shared by the edge mappers
  typedef struct packed {
    logic [DIM_W-1:0]   net;
    logic [DIM_W-1:0]   img;   // already saturated to MAX_IMAGE
    logic [SCALE_W-1:0] scale;
  } axis_cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/hpbd_edge_map.sv
// Maps one box edge from grid units to a whole image pixel (floor).
// Depends on hpbd_pkg for widths and the axis setup struct.
`default_nettype none

module hpbd_edge_map (
  input  logic signed [hpbd_pkg::EDGE_W-1:0]  edge2_i,
  input  hpbd_pkg::axis_cfg_t                 axis_i,
  input  logic                                add_one_i,
  output logic signed [hpbd_pkg::COORD_W-1:0] coord_o
);
  import hpbd_pkg::*;

  logic signed [DIST_W-1:0] delta;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] pos;

  // distance from network center, 1/512 pixel
  assign delta = DIST_W'(edge2_i * STRIDE) - DIST_W'(signed'({1'b0, axis_i.net, 8'b0}));

  assign prod = PROD_W'(delta) * PROD_W'(signed'({1'b0, axis_i.scale}));

  // recenter on the image and add the exclusive pixel where asked
  assign pos = prod
             + PROD_W'(signed'({1'b0, axis_i.img, 24'b0}))
             + PROD_W'(signed'({1'b0, add_one_i, 25'b0}));

  // floor; toward-zero differs only below zero, where clipping hides it
  assign coord_o = pos[PROD_W-1:FRAC_SHIFT];

endmodule

`default_nettype wire

>>> rtl/core/heatmap_peak_box_decoder_core.sv
// Heatmap peak box decoder top level: config registers, input register,
// peak test, an edge mapper for each box side, clipping and the result register.
// Depends on hpbd_pkg and hpbd_edge_map.
`default_nettype none

// Usage:
//   Input channel: one heatmap cell per beat (scores, offsets, sizes, grid
//   position, class) on in_valid_i / in_stall_o. Output channel: one box per
//   beat on out_valid_o / out_stall_i. Cells that are not peaks above the
//   threshold, or whose clipped box has no area, produce no output beat.
//   A box reaches out_valid_o through two registers: an accepted cell sits in
//   the input register, and its box is then loaded into the result register.
//   Throughput: one cell per cycle while the input is not stalled; the path
//   between the two registers holds one 25x25 multiply per edge, the adds and the clips.
//   When the receiver stalls, the result register holds its box; the input
//   register still drops non-peak cells, and the input stalls only when a
//   box waits in both registers.
//   Configuration: write cfg_data_i to register cfg_index_i while cfg_we_i
//   is high, only while the block is idle. Indexes 6 and 7 are ignored.
//   Reset (rst_ni low, asynchronous) empties both registers and loads the
//   default threshold, 512x512 network and image, and unit inverse scale.
module heatmap_peak_box_decoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [hpbd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hpbd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // cell input
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [hpbd_pkg::SCORE_W-1:0]        heat_score_i,
  input  logic [hpbd_pkg::SCORE_W-1:0]        pooled_score_i,
  input  logic signed [hpbd_pkg::OFS_W-1:0]   offset_x_i,
  input  logic signed [hpbd_pkg::OFS_W-1:0]   offset_y_i,
  input  logic [hpbd_pkg::SIZE_W-1:0]         size_w_i,
  input  logic [hpbd_pkg::SIZE_W-1:0]         size_h_i,
  input  logic [hpbd_pkg::CELL_W-1:0]         cell_col_i,
  input  logic [hpbd_pkg::CELL_W-1:0]         cell_row_i,
  input  logic [hpbd_pkg::CLASS_W-1:0]        class_index_i,
  // box output
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [hpbd_pkg::LEFT_W-1:0]         box_left_o,
  output logic [hpbd_pkg::LEFT_W-1:0]         box_top_o,
  output logic [hpbd_pkg::RIGHT_W-1:0]        box_right_o,
  output logic [hpbd_pkg::RIGHT_W-1:0]        box_bottom_o,
  output logic [hpbd_pkg::CLASS_W-1:0]        box_class_o,
  output logic [hpbd_pkg::SCORE_W-1:0]        box_score_o
);
  import hpbd_pkg::*;

  // configuration registers
  logic [SCORE_W-1:0] thresh_q;
  logic [DIM_W-1:0]   net_w_q, net_h_q, img_w_q, img_h_q;
  logic [SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= RST_SCORE_THRESHOLD;
      net_w_q  <= RST_DIM;
      net_h_q  <= RST_DIM;
      img_w_q  <= RST_DIM;
      img_h_q  <= RST_DIM;
      scale_q  <= RST_INVERSE_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SCORE_THRESHOLD: thresh_q <= cfg_data_i[SCORE_W-1:0];
        REG_NET_WIDTH:       net_w_q  <= cfg_data_i[DIM_W-1:0];
        REG_NET_HEIGHT:      net_h_q  <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_WIDTH:     img_w_q  <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT:    img_h_q  <= cfg_data_i[DIM_W-1:0];
        REG_INVERSE_SCALE:   scale_q  <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate image size for centering and clipping
  logic [DIM_W-1:0] img_w_sat, img_h_sat;
  assign img_w_sat = (img_w_q > DIM_W'(MAX_IMAGE)) ? DIM_W'(MAX_IMAGE) : img_w_q;
  assign img_h_sat = (img_h_q > DIM_W'(MAX_IMAGE)) ? DIM_W'(MAX_IMAGE) : img_h_q;

  // input register
  logic                      in_valid_q;
  logic [SCORE_W-1:0]        heat_q, pooled_q;
  logic signed [OFS_W-1:0]   ofs_x_q, ofs_y_q;
  logic [SIZE_W-1:0]         size_w_q, size_h_q;
  logic [CELL_W-1:0]         col_q, row_q;
  logic [CLASS_W-1:0]        cls_q;

  logic in_accept, advance, out_free, hit, out_load;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign advance    = in_valid_q && (!hit || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = in_valid_q && hit && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      heat_q   <= heat_score_i;
      pooled_q <= pooled_score_i;
      ofs_x_q  <= offset_x_i;
      ofs_y_q  <= offset_y_i;
      size_w_q <= size_w_i;
      size_h_q <= size_h_i;
      col_q    <= cell_col_i;
      row_q    <= cell_row_i;
      cls_q    <= class_index_i;
    end
  end

  // peak test and range checks
  logic peak;
  assign peak = (heat_q == pooled_q) && (pooled_q > thresh_q)
              && (32'(col_q) < 32'(GRID_DIM)) && (32'(row_q) < 32'(GRID_DIM))
              && (32'(cls_q) < 32'(NUM_CLASSES));

  // edges in 1/512 cell
  logic signed [EDGE_W-1:0] cx2, cy2, sw_e, sh_e;
  assign cx2  = EDGE_W'(signed'({1'b0, col_q, 9'b0})) + (EDGE_W'(ofs_x_q) <<< 1);
  assign cy2  = EDGE_W'(signed'({1'b0, row_q, 9'b0})) + (EDGE_W'(ofs_y_q) <<< 1);
  assign sw_e = EDGE_W'(signed'({1'b0, size_w_q}));
  assign sh_e = EDGE_W'(signed'({1'b0, size_h_q}));

  axis_cfg_t axis_x, axis_y;
  assign axis_x = '{net: net_w_q, img: img_w_sat, scale: scale_q};
  assign axis_y = '{net: net_h_q, img: img_h_sat, scale: scale_q};

  logic signed [COORD_W-1:0] l_raw, t_raw, r_raw, b_raw;

  hpbd_edge_map u_map_left (
    .edge2_i(cx2 - sw_e), .axis_i(axis_x), .add_one_i(1'b0), .coord_o(l_raw)
  );
  hpbd_edge_map u_map_top (
    .edge2_i(cy2 - sh_e), .axis_i(axis_y), .add_one_i(1'b0), .coord_o(t_raw)
  );
  hpbd_edge_map u_map_right (
    .edge2_i(cx2 + sw_e), .axis_i(axis_x), .add_one_i(1'b1), .coord_o(r_raw)
  );
  hpbd_edge_map u_map_bottom (
    .edge2_i(cy2 + sh_e), .axis_i(axis_y), .add_one_i(1'b1), .coord_o(b_raw)
  );

  // clip to the image
  logic signed [COORD_W-1:0] iw_s, ih_s, l_c, t_c, r_c, b_c;
  assign iw_s = COORD_W'(signed'({1'b0, img_w_sat}));
  assign ih_s = COORD_W'(signed'({1'b0, img_h_sat}));
  assign l_c  = (l_raw < 0) ? '0 : l_raw;
  assign t_c  = (t_raw < 0) ? '0 : t_raw;
  assign r_c  = (r_raw > iw_s) ? iw_s : r_raw;
  assign b_c  = (b_raw > ih_s) ? ih_s : b_raw;

  assign hit = peak && (r_c > l_c) && (b_c > t_c);

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      box_left_o   <= l_c[LEFT_W-1:0];
      box_top_o    <= t_c[LEFT_W-1:0];
      box_right_o  <= r_c[RIGHT_W-1:0];
      box_bottom_o <= b_c[RIGHT_W-1:0];
      box_class_o  <= cls_q;
      box_score_o  <= heat_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // every emitted box has positive area
  a_box_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (RIGHT_W'(box_left_o) < box_right_o)
                 && (RIGHT_W'(box_top_o) < box_bottom_o))
    else $error("box with no area emitted");

  // a rise of out_valid_o comes only from a peak held in the input register
  a_box_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q && hit))
    else $error("box emitted without a peak cell");

  // input stalls only while a box is waiting downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && hit && out_valid_o && out_stall_i))
    else $error("input stalled without a waiting box");
`endif

endmodule

`default_nettype wire
